// ===== design/fraction_reducer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// fraction_reducer_unit_defines
// Assertion macros shared by the fraction reducer modules. Each macro expects
// aclk and an active-low aresetn in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_UNIT_DEFINES_SVH
`define FRACTION_REDUCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FRU_ASSERT_NOW(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge aclk) disable iff (!aresetn) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication, disabled during reset
`define FRU_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge aclk) disable iff (!aresetn) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== design/frac_red_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_red_pkg
// Types, widths, control codes and the microcode table of the fraction
// reducer.
// ----------------------------------------------------------------------------
package frac_red_pkg;

    // field widths
    localparam int VALUE_BITS = 32;
    localparam int MAG_W      = VALUE_BITS - 1;
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int UPC_W      = 3;

    // payload of one input transfer
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] num_in;
        logic signed [VALUE_BITS-1:0] den_in;
    } frac_in_t;

    // payload of one result transfer
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] num_out;
        logic        [MAG_W-1:0]      den_out;
        logic                         zero_den;
    } frac_out_t;

    // wait conditions: the step holds until its condition is met
    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_IN   = 2'd1;
    localparam logic [1:0] WAIT_DIV  = 2'd2;
    localparam logic [1:0] WAIT_OUT  = 2'd3;

    // jump conditions, evaluated when the step completes
    localparam logic [1:0] JMP_NONE    = 2'd0;
    localparam logic [1:0] JMP_ALWAYS  = 2'd1;
    localparam logic [1:0] JMP_GCD_END = 2'd2;

    // datapath operations, committed when the step completes
    localparam logic [2:0] OP_NOP        = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_MOD_START  = 3'd2;
    localparam logic [2:0] OP_MOD_WB     = 3'd3;
    localparam logic [2:0] OP_DIVN_START = 3'd4;
    localparam logic [2:0] OP_NWB_DIVD   = 3'd5;
    localparam logic [2:0] OP_DEN_WB     = 3'd6;
    localparam logic [2:0] OP_EMIT       = 3'd7;

    // microprogram addresses
    localparam logic [UPC_W-1:0] UPC_IDLE    = 3'd0;
    localparam logic [UPC_W-1:0] UPC_TEST    = 3'd1;
    localparam logic [UPC_W-1:0] UPC_MOD     = 3'd2;
    localparam logic [UPC_W-1:0] UPC_MODWAIT = 3'd3;
    localparam logic [UPC_W-1:0] UPC_DIVN    = 3'd4;
    localparam logic [UPC_W-1:0] UPC_DIVD    = 3'd5;
    localparam logic [UPC_W-1:0] UPC_DENWB   = 3'd6;
    localparam logic [UPC_W-1:0] UPC_EMIT    = 3'd7;

    // one control word per step
    typedef struct packed {
        logic [1:0]       wait_sel;
        logic [1:0]       jump_sel;
        logic [UPC_W-1:0] target;
        logic [2:0]       op;
    } ctrl_word_t;

    // status the datapath reports back to the sequencer
    typedef struct packed {
        logic div_busy;
        logic gcd_end;
        logic out_free;
    } dp_status_t;

    // microcode ROM
    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_word_t cw;
        cw = '{wait_sel: WAIT_NONE, jump_sel: JMP_NONE, target: UPC_IDLE, op: OP_NOP};
        case (addr)
            UPC_IDLE: begin
                cw.wait_sel = WAIT_IN;
                cw.op       = OP_LOAD;
            end
            UPC_TEST: begin
                cw.jump_sel = JMP_GCD_END;
                cw.target   = UPC_DIVN;
            end
            UPC_MOD: begin
                cw.op = OP_MOD_START;
            end
            UPC_MODWAIT: begin
                cw.wait_sel = WAIT_DIV;
                cw.op       = OP_MOD_WB;
                cw.jump_sel = JMP_ALWAYS;
                cw.target   = UPC_TEST;
            end
            UPC_DIVN: begin
                cw.op = OP_DIVN_START;
            end
            UPC_DIVD: begin
                cw.wait_sel = WAIT_DIV;
                cw.op       = OP_NWB_DIVD;
            end
            UPC_DENWB: begin
                cw.wait_sel = WAIT_DIV;
                cw.op       = OP_DEN_WB;
            end
            UPC_EMIT: begin
                cw.wait_sel = WAIT_OUT;
                cw.op       = OP_EMIT;
                cw.jump_sel = JMP_ALWAYS;
                cw.target   = UPC_IDLE;
            end
            default: begin
                cw.jump_sel = JMP_ALWAYS;
                cw.target   = UPC_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== design/frac_red_div.sv =====
`timescale 1ns / 1ps
`include "fraction_reducer_unit_defines.svh"
// ----------------------------------------------------------------------------
// frac_red_div
// Shift-subtract divider giving quotient and remainder of two magnitudes.
// The divisor is first shifted up under the dividend, then one quotient bit
// is produced per cycle.
// ----------------------------------------------------------------------------
module frac_red_div
    import frac_red_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic             busy,
    output logic [MAG_W-1:0] quo,
    output logic [MAG_W-1:0] rem
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_SUB   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dv_reg, dv_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [MAG_W:0]   dv_dbl;
    logic             can_shift;
    logic [MAG_W:0]   diff;
    logic             ge;

    // alignment test and trial subtraction
    assign dv_dbl    = {dv_reg, 1'b0};
    assign can_shift = !dv_reg[MAG_W-1] && (dv_dbl <= {1'b0, rem_reg});
    assign diff      = {1'b0, rem_reg} - {1'b0, dv_reg};
    assign ge        = !diff[MAG_W];

    // next-state logic
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rem_next   = dividend;
                    dv_next    = divisor;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (can_shift) begin
                    dv_next  = dv_dbl[MAG_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end else begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                if (ge) begin
                    rem_next = diff[MAG_W-1:0];
                end
                quo_next = {quo_reg[MAG_W-2:0], ge};
                if (cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    dv_next  = dv_reg >> 1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    `FRU_ASSERT_NOW(a_start_when_idle, start, state_reg == ST_IDLE, "divider started while busy")

endmodule

// ===== design/frac_red_dp.sv =====
`timescale 1ns / 1ps
`include "fraction_reducer_unit_defines.svh"
// ----------------------------------------------------------------------------
// frac_red_dp
// Datapath of the fraction reducer: operand registers for the Euclidean
// remainder loop, the shared divider, sign handling and the result register.
// ----------------------------------------------------------------------------
module frac_red_dp
    import frac_red_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_word_t cw,
    input  logic       fire,
    input  frac_in_t   in_data,
    input  logic       out_ready,
    output logic       out_valid,
    output frac_out_t  out_data,
    output dp_status_t status
);

    logic [MAG_W-1:0] x_reg, x_next;
    logic [MAG_W-1:0] y_reg, y_next;
    logic [MAG_W-1:0] n_reg, n_next;
    logic [MAG_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic             flag_reg, flag_next;
    logic             x_gt_reg, x_gt_next;
    logic             out_valid_reg, out_valid_next;
    frac_out_t        out_data_reg, out_data_next;

    logic [MAG_W-1:0] in_n_mag;
    logic [MAG_W-1:0] in_d_mag;
    logic             in_n_neg;
    logic             in_d_neg;
    logic [MAG_W-1:0] gcd_val;
    logic             x_gt_y;
    logic             div_start;
    logic [MAG_W-1:0] div_a;
    logic [MAG_W-1:0] div_b;
    logic             div_busy;
    logic [MAG_W-1:0] div_quo;
    logic [MAG_W-1:0] div_rem;
    logic             out_free;
    logic [VALUE_BITS-1:0] n_ext;
    logic [VALUE_BITS-1:0] n_signed;

    // magnitude of a signed field, most negative value clamped
    function automatic logic [MAG_W-1:0] take_mag(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] neg_v;
        neg_v = ~v + VALUE_BITS'(1);
        if (!v[VALUE_BITS-1]) begin
            return v[MAG_W-1:0];
        end else if (v[MAG_W-1:0] == '0) begin
            return '1;
        end else begin
            return neg_v[MAG_W-1:0];
        end
    endfunction

    // input decode
    assign in_n_mag = take_mag(in_data.num_in);
    assign in_d_mag = take_mag(in_data.den_in);
    assign in_n_neg = in_data.num_in[VALUE_BITS-1];
    assign in_d_neg = in_data.den_in[VALUE_BITS-1];

    // one of x, y is zero once the loop ends, so the gcd is their OR
    assign gcd_val  = x_reg | y_reg;
    assign x_gt_y   = (x_reg > y_reg);
    assign out_free = !out_valid_reg || out_ready;

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_a     = n_reg;
        div_b     = gcd_val;
        case (cw.op)
            OP_MOD_START: begin
                div_start = fire;
                div_a     = x_gt_y ? x_reg : y_reg;
                div_b     = x_gt_y ? y_reg : x_reg;
            end
            OP_DIVN_START: begin
                div_start = fire;
                div_a     = n_reg;
            end
            OP_NWB_DIVD: begin
                div_start = fire;
                div_a     = d_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    frac_red_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // signed result numerator
    assign n_ext    = {1'b0, n_reg};
    assign n_signed = neg_reg ? (~n_ext + VALUE_BITS'(1)) : n_ext;

    // operation commit
    always_comb begin
        x_next         = x_reg;
        y_next         = y_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        flag_next      = flag_reg;
        x_gt_next      = x_gt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fire) begin
            case (cw.op)
                OP_LOAD: begin
                    neg_next  = (in_n_neg && (in_d_mag != '0) && !in_d_neg)
                             || (in_d_neg && (in_n_mag != '0) && !in_n_neg);
                    flag_next = (in_n_mag != '0) && (in_d_mag == '0);
                    n_next    = in_n_mag;
                    x_next    = in_n_mag;
                    // zero numerator reduces to 0/1
                    d_next    = (in_n_mag == '0) ? MAG_W'(1) : in_d_mag;
                    y_next    = (in_n_mag == '0) ? MAG_W'(1) : in_d_mag;
                end
                OP_MOD_START: begin
                    x_gt_next = x_gt_y;
                end
                OP_MOD_WB: begin
                    if (x_gt_reg) begin
                        x_next = div_rem;
                    end else begin
                        y_next = div_rem;
                    end
                end
                OP_NWB_DIVD: begin
                    n_next = div_quo;
                end
                OP_DEN_WB: begin
                    d_next = div_quo;
                end
                OP_EMIT: begin
                    out_data_next.num_out  = $signed(n_signed);
                    out_data_next.den_out  = d_reg;
                    out_data_next.zero_den = flag_reg;
                    out_valid_next         = 1'b1;
                end
                default: begin
                    x_next = x_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // operand and result registers
    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        neg_reg      <= neg_next;
        flag_reg     <= flag_next;
        x_gt_reg     <= x_gt_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.div_busy = div_busy;
    assign status.gcd_end  = (x_reg == '0) || (y_reg == '0);
    assign status.out_free = out_free;

    `FRU_ASSERT_NOW(a_div_nonzero, div_start, div_b != '0, "divider started with zero divisor")
    `FRU_ASSERT_NOW(a_emit_free, fire && (cw.op == OP_EMIT), out_free, "result overwrites pending transfer")
    `FRU_ASSERT_NOW(a_zero_den_flag, out_valid_reg && (out_data_reg.den_out == '0), out_data_reg.zero_den, "zero denominator without flag")

endmodule

// ===== design/frac_red_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_red_seq
// Microcode sequencer: step counter, control word fetch from the ROM, wait
// and conditional jump handling.
// ----------------------------------------------------------------------------
module frac_red_seq
    import frac_red_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  dp_status_t status,
    output ctrl_word_t cw,
    output logic       fire
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             wait_ok;
    logic             jump_taken;

    assign cw = ucode_rom(upc_reg);

    // wait condition of the current step
    always_comb begin
        case (cw.wait_sel)
            WAIT_NONE: wait_ok = 1'b1;
            WAIT_IN:   wait_ok = in_valid;
            WAIT_DIV:  wait_ok = !status.div_busy;
            WAIT_OUT:  wait_ok = status.out_free;
            default:   wait_ok = 1'b1;
        endcase
    end

    // jump condition of the current step
    always_comb begin
        case (cw.jump_sel)
            JMP_NONE:    jump_taken = 1'b0;
            JMP_ALWAYS:  jump_taken = 1'b1;
            JMP_GCD_END: jump_taken = status.gcd_end;
            default:     jump_taken = 1'b0;
        endcase
    end

    assign fire     = wait_ok;
    assign upc_next = !fire      ? upc_reg :
                      jump_taken ? cw.target : upc_reg + UPC_W'(1);

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== design/fraction_reducer_unit.sv =====
`timescale 1ns / 1ps
// Steps: load, then per Euclidean remainder step a test, a divider start and a wait for the
// remainder; a final test, division of numerator and denominator by the gcd, then emit.
// Items are handled one at a time, paced by the shared shift-subtract divider.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops m_valid.
// ----------------------------------------------------------------------------
// fraction_reducer_unit
// Reduces a signed fraction to lowest terms with a microcoded sequencer
// driving a datapath with one shared divider.
// ----------------------------------------------------------------------------
module fraction_reducer_unit
    import frac_red_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  frac_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output frac_out_t m_data
);

    ctrl_word_t cw;
    logic       fire;
    dp_status_t status;

    frac_red_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .status   (status),
        .cw       (cw),
        .fire     (fire)
    );

    frac_red_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cw        (cw),
        .fire      (fire),
        .in_data   (s_data),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (m_data),
        .status    (status)
    );

    // input transfer completes only in the load step
    assign s_ready = (cw.wait_sel == WAIT_IN);

endmodule
